>>> rtl/core/wab_pkg.sv
package wab_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int MATRIX_FRAC_BITS = 12;

    // matrix entry packing in a row register
    localparam int MAT_W   = 16;
    localparam int ROW_W   = 3 * MAT_W;
    localparam int CFG_W   = ROW_W;
    localparam int IDX_W   = 3;
    localparam int LEN_W   = MAT_W;
    localparam int SQ_W    = 2 * MAT_W;

    // doubled coordinates (sum and difference of two coordinates)
    localparam int C2_W    = COORD_WIDTH + 1;
    localparam int PC_W    = C2_W + MAT_W;
    localparam int PE_W    = C2_W + MAT_W + 1;
    localparam int ACC_W   = PE_W + 4;
    localparam int SHR     = MATRIX_FRAC_BITS + 1;
    localparam int FIN_W   = ACC_W - SHR + 1;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    // column length unit: three row passes, then one bit per cycle
    localparam int LEN_ROWS = 3;
    localparam int LEN_DONE = LEN_ROWS + LEN_W;
    localparam int LEN_CNT_W = $clog2(LEN_DONE + 1);

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROW0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd5;

    typedef struct packed {
        logic                       sphere;
        logic [2:0][C2_W-1:0]       c2;
        logic [2:0][C2_W-1:0]       h2;
        logic [C2_W-1:0]            r2;
    } item_t;

    typedef struct packed {
        logic [2:0][2:0][MAT_W-1:0] mat;   // [row][col]
        logic [2:0][COORD_WIDTH-1:0] shift;
        logic [2:0][LEN_W-1:0]      len;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] wmin;
        logic [2:0][COORD_WIDTH-1:0] wmax;
    } result_t;

endpackage

>>> rtl/core/wab_front.sv
module wab_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [wab_pkg::IDX_W-1:0]         cfg_index,
    input  logic [wab_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              push,
    input  logic                              q_full,
    input  logic                              bound_kind,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_x,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_y,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_z,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_x,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_y,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_z,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] radius,
    output logic                              full,
    output logic                              q_write,
    output wab_pkg::item_t                    item,
    output wab_pkg::cfg_t                     cfg
);
    import wab_pkg::*;

    logic [2:0][ROW_W-1:0]       row_reg;
    logic [2:0][COORD_WIDTH-1:0] shift_reg;
    logic [2:0][LEN_W-1:0]       len_reg, len_next;
    logic [2:0][SQ_W-1:0]        sq_reg, sq_next;
    logic [LEN_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                        busy;
    logic                        mat_write;

    assign mat_write = cfg_write &&
        (cfg_index == REG_ROW0 || cfg_index == REG_ROW1 || cfg_index == REG_ROW2);
    assign busy = (cnt_reg != LEN_CNT_W'(LEN_DONE));

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_reg[0]   <= ROW_W'(1) << MATRIX_FRAC_BITS;
            row_reg[1]   <= ROW_W'(1) << (MATRIX_FRAC_BITS + MAT_W);
            row_reg[2]   <= ROW_W'(1) << (MATRIX_FRAC_BITS + 2 * MAT_W);
            shift_reg    <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_ROW0:    row_reg[0]   <= cfg_data;
                REG_ROW1:    row_reg[1]   <= cfg_data;
                REG_ROW2:    row_reg[2]   <= cfg_data;
                REG_SHIFT_X: shift_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // column lengths: accumulate squares row by row, then settle one bit a cycle
    always_comb begin
        logic [LEN_CNT_W-1:0] step;
        logic [LEN_CNT_W-1:0] bitpos;
        logic [1:0]           row;
        logic signed [MAT_W-1:0] e;
        logic [SQ_W-1:0]      esq;
        logic [LEN_W-1:0]     trial;
        logic [SQ_W-1:0]      tsq;
        cnt_next = cnt_reg;
        sq_next  = sq_reg;
        len_next = len_reg;
        e        = '0;
        esq      = '0;
        trial    = '0;
        tsq      = '0;
        step     = cnt_reg - LEN_CNT_W'(LEN_ROWS);
        bitpos   = LEN_CNT_W'(LEN_W - 1) - step;
        row      = cnt_reg[1:0];
        if (mat_write) begin
            cnt_next = '0;
            sq_next  = '0;
            len_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg + 1'b1;
            for (int j = 0; j < 3; j++) begin
                if (cnt_reg < LEN_CNT_W'(LEN_ROWS)) begin
                    e   = row_reg[row][MAT_W*j +: MAT_W];
                    esq = SQ_W'($signed(e) * $signed(e));
                    sq_next[j] = sq_reg[j] + esq;
                end else begin
                    trial = len_reg[j] | (LEN_W'(1) << bitpos);
                    tsq   = trial * trial;
                    if (tsq <= sq_reg[j]) begin
                        len_next[j] = trial;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= LEN_CNT_W'(LEN_DONE);
            len_reg <= {3{LEN_W'(1) << MATRIX_FRAC_BITS}};
        end else begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk) begin
        sq_reg <= sq_next;
    end

    // classify the incoming beat
    always_comb begin
        logic signed [C2_W-1:0] lo [3];
        logic signed [C2_W-1:0] hi [3];
        logic signed [C2_W-1:0] h2 [3];
        logic signed [C2_W-1:0] big;
        lo[0] = C2_W'(min_x); lo[1] = C2_W'(min_y); lo[2] = C2_W'(min_z);
        hi[0] = C2_W'(max_x); hi[1] = C2_W'(max_y); hi[2] = C2_W'(max_z);
        for (int i = 0; i < 3; i++) begin
            h2[i]      = hi[i] - lo[i];
            item.c2[i] = hi[i] + lo[i];
            item.h2[i] = h2[i];
        end
        item.sphere = bound_kind;
        big = h2[0];
        if (h2[1] > big) big = h2[1];
        if (h2[2] > big) big = h2[2];
        item.r2 = '0;
        if (bound_kind) begin
            if (radius > 0) begin
                item.r2 = {radius, 1'b0};
            end else if (big > 0) begin
                item.r2 = big;
            end else begin
                item.c2 = '0;
                item.r2 = C2_W'(2) << 16;
            end
        end
    end

    assign full    = q_full || busy;
    assign q_write = push && !full;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cfg.mat[i][j] = row_reg[i][MAT_W*j +: MAT_W];
            end
        end
        cfg.shift = shift_reg;
        cfg.len   = len_reg;
    end

endmodule

>>> rtl/core/wab_queue.sv
module wab_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  wab_pkg::item_t wr_item,
    input  logic           rd,
    output wab_pkg::item_t rd_item,
    output logic           q_full,
    output logic           q_empty
);
    import wab_pkg::*;

    item_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wp_reg, rp_reg;
    logic [Q_PTR_W:0]     cnt_reg;

    assign q_full  = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_item = mem[rp_reg];

    // advance pointers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (Q_PTR_W+1)'(wr) - (Q_PTR_W+1)'(rd);
        end
    end

    always_ff @(posedge clk) begin
        if (wr) mem[wp_reg] <= wr_item;
    end

endmodule

>>> rtl/core/wab_back.sv
module wab_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wab_pkg::cfg_t  cfg,
    input  wab_pkg::item_t q_item,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output wab_pkg::result_t res
);
    import wab_pkg::*;

    localparam logic signed [FIN_W-1:0] MAXV = FIN_W'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
    localparam logic signed [FIN_W-1:0] MINV = -MAXV - 1;

    logic signed [PC_W-1:0]  pc_reg [3][3];
    logic signed [PE_W-1:0]  pe_reg [3][3];
    logic signed [PE_W-1:0]  ps_reg [3];
    logic                    sph1_reg;
    logic signed [ACC_W-1:0] cs_reg [3];
    logic signed [ACC_W-1:0] es_reg [3];
    logic                    v1_reg, v2_reg;
    result_t                 fin;
    result_t                 mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]    wp_reg, rp_reg;
    logic [OUT_PTR_W:0]      occ_reg;
    logic [OUT_PTR_W+1:0]    committed;
    logic                    out_rd;

    // reserve a result slot for every beat in flight
    assign committed = (OUT_PTR_W+2)'(occ_reg) + (OUT_PTR_W+2)'(v1_reg)
                     + (OUT_PTR_W+2)'(v2_reg);
    assign q_pop  = !q_empty && (committed < (OUT_PTR_W+2)'(OUT_DEPTH));
    assign empty  = (occ_reg == '0);
    assign out_rd = pop && !empty;
    assign res    = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
        end
    end

    // stage one: products
    always_ff @(posedge clk) begin
        logic signed [MAT_W:0] mx;
        logic        [MAT_W:0] am;
        sph1_reg <= q_item.sphere;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mx = {cfg.mat[i][j][MAT_W-1], cfg.mat[i][j]};
                am = mx[MAT_W] ? (MAT_W+1)'(-mx) : mx;
                pc_reg[i][j] <= $signed(q_item.c2[i]) * $signed(cfg.mat[i][j]);
                pe_reg[i][j] <= $signed(q_item.h2[i]) * $signed(am);
            end
        end
        for (int j = 0; j < 3; j++) begin
            ps_reg[j] <= $signed(q_item.r2) * $signed({1'b0, cfg.len[j]});
        end
    end

    // stage two: center and extent sums
    always_ff @(posedge clk) begin
        for (int j = 0; j < 3; j++) begin
            cs_reg[j] <= ACC_W'(pc_reg[0][j]) + ACC_W'(pc_reg[1][j]) + ACC_W'(pc_reg[2][j]);
            if (sph1_reg) begin
                es_reg[j] <= ACC_W'(ps_reg[j]);
            end else begin
                es_reg[j] <= ACC_W'(pe_reg[0][j]) + ACC_W'(pe_reg[1][j])
                           + ACC_W'(pe_reg[2][j]);
            end
        end
    end

    // stage three: floor, translate, saturate
    always_comb begin
        logic signed [ACC_W-1:0] lo, hi;
        logic signed [FIN_W-1:0] flo, fhi, t;
        for (int j = 0; j < 3; j++) begin
            lo  = cs_reg[j] - es_reg[j];
            hi  = cs_reg[j] + es_reg[j];
            t   = FIN_W'($signed(cfg.shift[j]));
            flo = FIN_W'(lo >>> SHR) + t;
            fhi = FIN_W'(hi >>> SHR) + t;
            if (flo > MAXV)      fin.wmin[j] = COORD_WIDTH'(MAXV);
            else if (flo < MINV) fin.wmin[j] = COORD_WIDTH'(MINV);
            else                 fin.wmin[j] = flo[COORD_WIDTH-1:0];
            if (fhi > MAXV)      fin.wmax[j] = COORD_WIDTH'(MAXV);
            else if (fhi < MINV) fin.wmax[j] = COORD_WIDTH'(MINV);
            else                 fin.wmax[j] = fhi[COORD_WIDTH-1:0];
        end
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            occ_reg <= '0;
        end else begin
            if (v2_reg) wp_reg <= wp_reg + 1'b1;
            if (out_rd) rp_reg <= rp_reg + 1'b1;
            occ_reg <= occ_reg + (OUT_PTR_W+1)'(v2_reg) - (OUT_PTR_W+1)'(out_rd);
        end
    end

    always_ff @(posedge clk) begin
        if (v2_reg) mem[wp_reg] <= fin;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (occ_reg != (OUT_PTR_W+1)'(OUT_DEPTH)) || out_rd)
        else $error("result queue overflow");
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        committed <= (OUT_PTR_W+2)'(OUT_DEPTH))
        else $error("more beats in flight than result slots");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> v1_reg ##1 v2_reg)
        else $error("beat lost in back pipeline");

endmodule

>>> rtl/core/world_aabb_from_box_or_sphere_top.sv
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | push / full        | bound_kind, min_x..max_z, radius
// result   | empty / pop        | world_min_x..z, world_max_x..z
// config   | cfg_write          | cfg_index, cfg_data
//
// One beat per cycle while full is low; a taken beat passes the queue,
// the product stage, the sum stage and the result queue to the result ports.
// Asynchronous active-low reset; the matrix resets to identity.
// A write to a matrix row runs the column length unit (three square
// passes, then one bit per cycle); full stays high meanwhile.
// Front and back are parted by a four-beat queue; the back takes a beat
// only when a result slot is reserved, so pop stalls never drop data.
module world_aabb_from_box_or_sphere_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [wab_pkg::IDX_W-1:0]              cfg_index,
    input  logic [wab_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   bound_kind,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_x,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_y,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] min_z,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_x,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_y,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] max_z,
    input  logic signed [wab_pkg::COORD_WIDTH-1:0] radius,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_min_x,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_min_y,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_min_z,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_max_x,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_max_y,
    output logic signed [wab_pkg::COORD_WIDTH-1:0] world_max_z
);
    import wab_pkg::*;

    item_t   f_item, q_item;
    cfg_t    cfg;
    result_t res;
    logic    q_write, q_full, q_empty, q_pop;

    wab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .q_full     (q_full),
        .bound_kind (bound_kind),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .radius     (radius),
        .full       (full),
        .q_write    (q_write),
        .item       (f_item),
        .cfg        (cfg)
    );

    wab_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_item (f_item),
        .rd      (q_pop),
        .rd_item (q_item),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    wab_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_item  (q_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign world_min_x = res.wmin[0];
    assign world_min_y = res.wmin[1];
    assign world_min_z = res.wmin[2];
    assign world_max_x = res.wmax[0];
    assign world_max_y = res.wmax[1];
    assign world_max_z = res.wmax[2];

endmodule

>>> test/world_aabb_from_box_or_sphere_top_test.sv
`timescale 1ns / 100ps

module world_aabb_from_box_or_sphere_top_test;

    import wab_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic              sphere;
        logic signed [31:0] lo[3];
        logic signed [31:0] hi[3];
        logic signed [31:0] rad;
    } box_req_t;

    typedef struct {
        logic signed [31:0] wmin[3];
        logic signed [31:0] wmax[3];
    } world_box_t;

    // track the transform and the world boxes still owed by the block
    class aabb_scoreboard;
        logic [ROW_W-1:0]   rows[3];
        logic signed [31:0] shift[3];
        world_box_t         owed[$];
        int                 errors;

        function new();
            rows[0] = 48'h0000_0000_1000;
            rows[1] = 48'h0000_1000_0000;
            rows[2] = 48'h1000_0000_0000;
            shift[0] = 0;
            shift[1] = 0;
            shift[2] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ROW0:    rows[0] = data;
                REG_ROW1:    rows[1] = data;
                REG_ROW2:    rows[2] = data;
                REG_SHIFT_X: shift[0] = data[31:0];
                REG_SHIFT_Y: shift[1] = data[31:0];
                REG_SHIFT_Z: shift[2] = data[31:0];
                default:     ;
            endcase
        endfunction

        function longint col_len(longint unsigned sq);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sq)
                    root = trial;
            end
            return longint'(root);
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // work out the world box for one accepted beat
        function void note_input(box_req_t r);
            longint     m[3][3];
            longint     c2[3];
            longint     h2[3];
            longint     len[3];
            longint     r2;
            longint     ctr;
            longint     ext;
            world_box_t w;
            r2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                c2[i] = longint'(r.lo[i]) + longint'(r.hi[i]);
                h2[i] = longint'(r.hi[i]) - longint'(r.lo[i]);
                for (int j = 0; j < 3; j++)
                    m[i][j] = longint'($signed(rows[i][16*j +: 16]));
            end
            if (r.sphere)
            begin
                if (r.rad > 0)
                    r2 = 2 * longint'(r.rad);
                else
                begin
                    r2 = h2[0];
                    if (h2[1] > r2) r2 = h2[1];
                    if (h2[2] > r2) r2 = h2[2];
                    // degenerate box: unit sphere at the origin
                    if (r2 <= 0)
                    begin
                        c2[0] = 0;
                        c2[1] = 0;
                        c2[2] = 0;
                        r2 = 64'sd2 << 16;
                    end
                end
                for (int j = 0; j < 3; j++)
                    len[j] = col_len(m[0][j] * m[0][j] + m[1][j] * m[1][j]
                                     + m[2][j] * m[2][j]);
            end
            for (int j = 0; j < 3; j++)
            begin
                ctr = 0;
                ext = 0;
                for (int i = 0; i < 3; i++)
                begin
                    ctr += c2[i] * m[i][j];
                    if (!r.sphere)
                        ext += h2[i] * (m[i][j] < 0 ? -m[i][j] : m[i][j]);
                end
                if (r.sphere)
                    ext = r2 * len[j];
                w.wmin[j] = clamp(((ctr - ext) >>> SHR) + longint'(shift[j]));
                w.wmax[j] = clamp(((ctr + ext) >>> SHR) + longint'(shift[j]));
            end
            owed.push_back(w);
        endfunction

        task report(string what, logic signed [31:0] got, logic signed [31:0] want);
            errors++;
            $display("mismatch %s: got %h, want %h", what, got, want);
        endtask

        task check(world_box_t got);
            world_box_t want;
            if (owed.size() == 0)
            begin
                report("unexpected beat", got.wmin[0], 0);
                return;
            end
            want = owed.pop_front();
            for (int j = 0; j < 3; j++)
            begin
                if (got.wmin[j] !== want.wmin[j])
                    report($sformatf("world_min[%0d]", j), got.wmin[j], want.wmin[j]);
                if (got.wmax[j] !== want.wmax[j])
                    report($sformatf("world_max[%0d]", j), got.wmax[j], want.wmax[j]);
            end
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    push;
    logic                    full;
    logic                    bound_kind;
    logic signed [31:0]      min_x, min_y, min_z, max_x, max_y, max_z, radius;
    logic                    empty;
    logic                    pop;
    logic signed [31:0]      world_min_x, world_min_y, world_min_z;
    logic signed [31:0]      world_max_x, world_max_y, world_max_z;

    aabb_scoreboard sb;
    int  beats_sent;
    bit  steady;
    bit  held;
    int  quiet_cycles;

    world_aabb_from_box_or_sphere_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .bound_kind  (bound_kind),
        .min_x       (min_x),
        .min_y       (min_y),
        .min_z       (min_z),
        .max_x       (max_x),
        .max_y       (max_y),
        .max_z       (max_z),
        .radius      (radius),
        .empty       (empty),
        .pop         (pop),
        .world_min_x (world_min_x),
        .world_min_y (world_min_y),
        .world_min_z (world_min_z),
        .world_max_x (world_max_x),
        .world_max_y (world_max_y),
        .world_max_z (world_max_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // write one register, then let the column length unit settle
    task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, data);
        repeat (30) @(posedge clk);
    endtask

    task load_transform(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                        logic [ROW_W-1:0] r2, logic [31:0] sx,
                        logic [31:0] sy, logic [31:0] sz);
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
        write_reg(REG_SHIFT_X, {16'h0, sx});
        write_reg(REG_SHIFT_Y, {16'h0, sy});
        write_reg(REG_SHIFT_Z, {16'h0, sz});
    endtask

    // offer one beat, holding it until the block takes it
    task send_box(box_req_t r);
        if (!steady && $urandom_range(99) < 18)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        bound_kind <= r.sphere;
        min_x  <= r.lo[0];
        min_y  <= r.lo[1];
        min_z  <= r.lo[2];
        max_x  <= r.hi[0];
        max_y  <= r.hi[1];
        max_z  <= r.hi[2];
        radius <= r.rad;
        push   <= 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_input(r);
        beats_sent++;
    endtask

    task drain();
        push <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function logic signed [31:0] pick_coord(int style);
        case (style)
            0:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            1:       return $urandom;
            default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
        endcase
    endfunction

    function box_req_t make_box(logic kind, logic signed [31:0] lo,
                                logic signed [31:0] hi, logic signed [31:0] rad);
        box_req_t r;
        r.sphere = kind;
        for (int i = 0; i < 3; i++)
        begin
            r.lo[i] = lo;
            r.hi[i] = hi;
        end
        r.rad = rad;
        return r;
    endfunction

    function box_req_t random_box();
        box_req_t r;
        int style;
        int shape;
        style = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        r.sphere = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++)
        begin
            r.lo[i] = pick_coord(style);
            r.hi[i] = pick_coord(style);
            // mostly well-formed boxes, some flat, some inverted
            if (shape < 7 && r.hi[i] < r.lo[i])
                {r.lo[i], r.hi[i]} = {r.hi[i], r.lo[i]};
            else if (shape == 7)
                r.hi[i] = r.lo[i];
        end
        case ($urandom_range(0, 3))
            0:       r.rad = 0;
            1:       r.rad = -$signed({1'b0, $urandom_range(0, 32'h7fff_ffff)});
            2:       r.rad = $urandom_range(1, 32'h0010_0000);
            default: r.rad = $urandom;
        endcase
        return r;
    endfunction

    task run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            steady = (n >= count / 3 && n < count / 3 + 60);
            send_box(random_box());
        end
        steady = 1'b0;
        drain();
    endtask

    // result side: check each beat, pop at random, stall once for a long stretch
    initial
    begin
        pop = 1'b0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check('{wmin: '{world_min_x, world_min_y, world_min_z},
                           wmax: '{world_max_x, world_max_y, world_max_z}});
            if (!held && beats_sent >= 400)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= steady || ($urandom_range(99) >= 35);
        end
    end

    // end the run if nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || cfg_write || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        beats_sent = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        bound_kind = 1'b0;
        {min_x, min_y, min_z, max_x, max_y, max_z, radius} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);

        // directed beats under the reset transform
        send_box(make_box(1'b0, 0, 0, 0));
        send_box(make_box(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 0));
        send_box(make_box(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 0));
        send_box(make_box(1'b0, 32'sh0001_0000, 32'sh0003_0001, 32'sh7fff_ffff));
        send_box(make_box(1'b1, 32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000));
        send_box(make_box(1'b1, 32'sh0001_0000, 32'sh0005_0000, 0));
        send_box(make_box(1'b1, 32'sh0001_0000, 32'sh0001_0000, -1));
        send_box(make_box(1'b1, 32'sh0003_0000, 32'sh0001_0000, 32'sh8000_0000));
        send_box(make_box(1'b1, 32'sh0000_0000, 32'sh0000_0001, 0));
        send_box(make_box(1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_box(make_box(1'b1, 32'sh8000_0000, 32'sh8000_0000, 0));
        send_box(make_box(1'b0, -1, -1, -1));
        drain();

        // rotation-like matrix with shifts; spare indexes must change nothing
        load_transform(48'h0000_0b50_0b50, 48'h0000_0b50_f4b0, 48'h1000_0000_0000,
                       32'h0010_0000, 32'hfff0_0000, 32'h0000_8000);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        send_box(make_box(1'b0, -32'sh0002_0000, 32'sh0002_0000, 0));
        send_box(make_box(1'b1, -32'sh0002_0000, 32'sh0002_0000, 0));
        run_random(350);

        // most negative entries, saturating shifts
        load_transform(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                       32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_box(make_box(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 0));
        send_box(make_box(1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
        run_random(250);

        // most positive entries
        load_transform(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
                       32'h8000_0000, 32'h7fff_ffff, 32'h0);
        run_random(250);

        // zero matrix
        load_transform('0, '0, '0, 32'h0, 32'h0, 32'h0);
        run_random(100);

        // random transforms
        for (int p = 0; p < 4; p++)
        begin
            load_transform({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom, $urandom, $urandom);
            run_random(140);
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
